@@ src/hpvc_pkg.sv @@
// ----------------------------------------------------------------------------
// hpvc_pkg
// Shared types and constants for the heading proportional velocity control
// unit: CORDIC datapath widths, the arctangent table and register indexes.
// ----------------------------------------------------------------------------
package hpvc_pkg;

    localparam int DATA_W     = 32;
    localparam int XY_W       = 35;
    localparam int Z_W        = 37;
    localparam int ANGLE_FRAC = 32;
    localparam int MAX_STEPS  = 24;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] REG_KP_LINEAR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KP_ANGULAR = 2'd1;

    localparam logic signed [Z_W-1:0] PI_Q32 = 37'sd13493037705;

    typedef struct packed {
        logic signed [XY_W-1:0]   x;
        logic signed [XY_W-1:0]   y;
        logic signed [Z_W-1:0]    z;
        logic signed [DATA_W-1:0] ex;
        logic                     origin;
    } cordic_t;

    // atan(2^-step) * 2^32, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_q32(input int step);
        logic signed [Z_W-1:0] a;
        case (step)
            0:       a = 37'sd3373259426;
            1:       a = 37'sd1991351318;
            2:       a = 37'sd1052175346;
            3:       a = 37'sd534100635;
            4:       a = 37'sd268086748;
            5:       a = 37'sd134174063;
            6:       a = 37'sd67103403;
            7:       a = 37'sd33553749;
            8:       a = 37'sd16777131;
            9:       a = 37'sd8388597;
            10:      a = 37'sd4194303;
            11:      a = 37'sd2097152;
            12:      a = 37'sd1048576;
            13:      a = 37'sd524288;
            14:      a = 37'sd262144;
            15:      a = 37'sd131072;
            16:      a = 37'sd65536;
            17:      a = 37'sd32768;
            18:      a = 37'sd16384;
            19:      a = 37'sd8192;
            20:      a = 37'sd4096;
            21:      a = 37'sd2048;
            22:      a = 37'sd1024;
            23:      a = 37'sd512;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

@@ src/heading_proportional_velocity_control_unit.sv @@
// ----------------------------------------------------------------------------
// heading_proportional_velocity_control_unit
// Forward command kp_linear * x (zero for x < 0) and turning command
// kp_angular * atan2(y, x), Q16.16, saturated.
// ----------------------------------------------------------------------------
// One error beat is taken every clock (busy stays low) and its result passes
// through quadrant correction, one cell per CORDIC iteration, angle rounding
// and the multiply-and-clip unit, all registered. Each result is shown for a
// single cycle with done high; the receiver cannot stall, so it must take every
// beat as it comes. Gains are written through cfg_we / cfg_addr / cfg_wdata;
// the user must write them only while no beat is in flight; the block itself
// does not enforce this.
module heading_proportional_velocity_control_unit #(
    parameter int CORDIC_STEPS = 16,
    parameter int FRAC_BITS    = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [hpvc_pkg::DATA_W-1:0]    error_x,
    input  logic signed [hpvc_pkg::DATA_W-1:0]    error_y,
    input  logic                                  cfg_we,
    input  logic        [hpvc_pkg::CFG_IDX_W-1:0] cfg_addr,
    input  logic        [hpvc_pkg::DATA_W-1:0]    cfg_wdata,
    output logic                                  done,
    output logic signed [hpvc_pkg::DATA_W-1:0]    forward_velocity,
    output logic signed [hpvc_pkg::DATA_W-1:0]    turn_velocity,
    output logic                                  saturated
);
    import hpvc_pkg::*;

    localparam int ANG_SHIFT = ANGLE_FRAC - FRAC_BITS;
    localparam logic signed [Z_W-1:0] ANG_RND = Z_W'(1) <<< (ANG_SHIFT - 1);
    localparam int LAT = CORDIC_STEPS + 4;

    logic signed [DATA_W-1:0] kp_linear_reg;
    logic signed [DATA_W-1:0] kp_angular_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_linear_reg  <= '0;
            kp_angular_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_KP_LINEAR:  kp_linear_reg  <= cfg_wdata;
                REG_KP_ANGULAR: kp_angular_reg <= cfg_wdata;
                default:        ;
            endcase
        end
    end

    // quadrant correction
    logic    accept;
    logic    pre_valid_reg;
    cordic_t pre_reg;
    cordic_t pre_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        pre_next.ex     = error_x;
        pre_next.origin = (error_x == '0) && (error_y == '0);
        pre_next.x      = XY_W'(error_x);
        pre_next.y      = XY_W'(error_y);
        pre_next.z      = '0;
        if (error_x[DATA_W-1])
        begin
            pre_next.x = -XY_W'(error_x);
            pre_next.y = -XY_W'(error_y);
            pre_next.z = error_y[DATA_W-1] ? -PI_Q32 : PI_Q32;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_valid_reg <= 1'b0;
        else
            pre_valid_reg <= accept;
    end

    always_ff @(posedge clk)
    begin
        pre_reg <= pre_next;
    end

    // cell chain
    logic    chain_valid [0:CORDIC_STEPS];
    cordic_t chain_data  [0:CORDIC_STEPS];

    assign chain_valid[0] = pre_valid_reg;
    assign chain_data[0]  = pre_reg;

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_cell
        hpvc_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (chain_valid[i]),
            .data_in   (chain_data[i]),
            .valid_out (chain_valid[i+1]),
            .data_out  (chain_data[i+1])
        );
    end

    // angle rounding
    cordic_t                  last;
    logic signed [Z_W-1:0]    z_rnd;
    logic                     rnd_valid_reg;
    logic signed [DATA_W-1:0] ang_reg;
    logic signed [DATA_W-1:0] ang_next;
    logic signed [DATA_W-1:0] ex_reg;

    assign last  = chain_data[CORDIC_STEPS];
    assign z_rnd = (last.z + ANG_RND) >>> ANG_SHIFT;

    always_comb
    begin
        ang_next = z_rnd[DATA_W-1:0];
        if (last.origin)
            ang_next = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rnd_valid_reg <= 1'b0;
        else
            rnd_valid_reg <= chain_valid[CORDIC_STEPS];
    end

    always_ff @(posedge clk)
    begin
        ang_reg <= ang_next;
        ex_reg  <= last.ex;
    end

    // products
    logic fwd_valid;
    logic fwd_sat;
    logic turn_valid;
    logic turn_sat;

    hpvc_product #(
        .FRAC_BITS (FRAC_BITS)
    ) u_fwd (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (rnd_valid_reg),
        .enable    (!ex_reg[DATA_W-1]),
        .a         (kp_linear_reg),
        .b         (ex_reg),
        .valid_out (fwd_valid),
        .value     (forward_velocity),
        .sat       (fwd_sat)
    );

    hpvc_product #(
        .FRAC_BITS (FRAC_BITS)
    ) u_turn (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (rnd_valid_reg),
        .enable    (1'b1),
        .a         (kp_angular_reg),
        .b         (ang_reg),
        .valid_out (turn_valid),
        .value     (turn_velocity),
        .sat       (turn_sat)
    );

    assign done      = fwd_valid;
    assign saturated = fwd_sat || turn_sat;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("beat accepted without result after pipeline latency");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("result without matching accepted beat");

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid == turn_valid)
        else $error("product lanes out of step");

    a_behind_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(accept && error_x[DATA_W-1], LAT) |-> forward_velocity == '0)
        else $error("forward command non-zero for target behind");

endmodule

@@ src/hpvc_cordic_cell.sv @@
// ----------------------------------------------------------------------------
// hpvc_cordic_cell
// One registered vectoring CORDIC iteration; cells are chained, one per step.
// ----------------------------------------------------------------------------
module hpvc_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid_in,
    input  hpvc_pkg::cordic_t data_in,
    output logic              valid_out,
    output hpvc_pkg::cordic_t data_out
);
    import hpvc_pkg::*;

    localparam logic signed [Z_W-1:0] ATAN = atan_q32(STEP);

    logic    valid_reg;
    cordic_t data_reg;
    cordic_t data_next;

    always_comb
    begin
        data_next = data_in;
        if (!data_in.y[XY_W-1])
        begin
            data_next.x = data_in.x + (data_in.y >>> STEP);
            data_next.y = data_in.y - (data_in.x >>> STEP);
            data_next.z = data_in.z + ATAN;
        end
        else
        begin
            data_next.x = data_in.x - (data_in.y >>> STEP);
            data_next.y = data_in.y + (data_in.x >>> STEP);
            data_next.z = data_in.z - ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_in;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

@@ src/hpvc_product.sv @@
// ----------------------------------------------------------------------------
// hpvc_product
// Gated signed 32x32 product, then floor shift by FRAC_BITS and clip to
// 32 bits with a saturation flag. Two register stages.
// ----------------------------------------------------------------------------
module hpvc_product #(
    parameter int FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               valid_in,
    input  logic                               enable,
    input  logic signed [hpvc_pkg::DATA_W-1:0] a,
    input  logic signed [hpvc_pkg::DATA_W-1:0] b,
    output logic                               valid_out,
    output logic signed [hpvc_pkg::DATA_W-1:0] value,
    output logic                               sat
);
    import hpvc_pkg::*;

    localparam int P_W = 2 * DATA_W;
    localparam logic signed [P_W-1:0] MAX_P =  P_W'(signed'({1'b0, {(DATA_W-1){1'b1}}}));
    localparam logic signed [P_W-1:0] MIN_P = -P_W'(signed'({1'b0, {(DATA_W-1){1'b1}}})) - 1;

    logic                     mul_valid_reg;
    logic signed [P_W-1:0]    prod_reg;
    logic signed [P_W-1:0]    prod_next;
    logic signed [P_W-1:0]    shifted;
    logic                     out_valid_reg;
    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     sat_reg;
    logic                     sat_next;

    always_comb
    begin
        prod_next = '0;
        if (enable)
            prod_next = a * b;
    end

    always_comb
    begin
        shifted = prod_reg >>> FRAC_BITS;
        sat_next = 1'b0;
        value_next = shifted[DATA_W-1:0];
        if (shifted > MAX_P)
        begin
            value_next = MAX_P[DATA_W-1:0];
            sat_next = 1'b1;
        end
        else if (shifted < MIN_P)
        begin
            value_next = MIN_P[DATA_W-1:0];
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mul_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mul_valid_reg <= valid_in;
            out_valid_reg <= mul_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= prod_next;
        value_reg <= value_next;
        sat_reg   <= sat_next;
    end

    assign valid_out = out_valid_reg;
    assign value     = value_reg;
    assign sat       = sat_reg;

endmodule
